// ===== sv/cvsd_pkg.sv =====
// Package for the cross-venue spread detector: sizes, defaults and the
// front/back command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cvsd_pkg;
  localparam int SymbolCountDefault = 64;
  localparam int VenueCountDefault = 8;
  localparam int FractionBitsDefault = 16;
  localparam logic [31:0] ThresholdReset = 32'd66;
  localparam int SymW = 6;
  localparam int VenW = 3;
  localparam int PriceW = 32;

  typedef struct packed {
    logic [SymW-1:0]   sym;
    logic [VenW-1:0]   buy_venue;
    logic [VenW-1:0]   sell_venue;
    logic [PriceW-1:0] lo_ticks;
    logic [PriceW-1:0] hi_ticks;
  } cand_t;

  typedef enum logic [2:0] {
    FE_CLEAR, FE_IDLE, FE_SCAN, FE_LAST, FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE, BE_DIV, BE_CMP, BE_EMIT
  } be_state_t;
endpackage
`default_nettype wire

// ===== sv/cross_venue_spread_detector_unit.sv =====
// Top level of the cross-venue spread detector: threshold register,
// front end and back end. Depends on cvsd_pkg, cvsd_front, cvsd_back.
//
//  channel  | handshake        | beat
//  input    | push / full      | symbol_index, venue_index, quote_ticks
//  result   | pop / empty      | signal_* , spread_ratio, last_of_pair
//  config   | cfg_valid/ready  | cfg_data (spread_threshold)
//
// After reset a clearing pass over all SYMBOL_COUNT*2^ceil(log2 VENUE_COUNT)
// table entries (512 by default) holds full high.
// Front: each update is accepted, read once per venue from the table, given a
// last compare and handed off; the hand-off waits while the back end is busy.
// Back: restoring division, then two beats when the ratio meets the threshold.
// Front and back overlap through a one-entry candidate register.
`timescale 1ns / 1ps
`default_nettype none
module cross_venue_spread_detector_unit #(
  parameter int SYMBOL_COUNT = cvsd_pkg::SymbolCountDefault,
  parameter int VENUE_COUNT = cvsd_pkg::VenueCountDefault,
  parameter int FRACTION_BITS = cvsd_pkg::FractionBitsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [cvsd_pkg::SymW-1:0] symbol_index,
  input  wire logic [cvsd_pkg::VenW-1:0] venue_index,
  input  wire logic [31:0]               quote_ticks,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [cvsd_pkg::SymW-1:0]      signal_symbol,
  output logic [cvsd_pkg::VenW-1:0]      signal_venue,
  output logic                           signal_side,
  output logic [31:0]                    signal_price,
  output logic [31:0]                    spread_ratio,
  output logic                           last_of_pair,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [31:0]               cfg_data
);
  logic [31:0] threshold;
  logic cand_valid, cand_ready;
  cvsd_pkg::cand_t cand;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) threshold <= cvsd_pkg::ThresholdReset;
    else if (cfg_valid) threshold <= cfg_data;
  end

  cvsd_front #(.SYMBOL_COUNT(SYMBOL_COUNT), .VENUE_COUNT(VENUE_COUNT)) u_front (
    .clk, .rst, .push, .full, .symbol_index, .venue_index, .quote_ticks,
    .cand_valid, .cand_ready, .cand
  );

  cvsd_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .cand_valid, .cand_ready, .cand, .threshold, .empty, .pop,
    .signal_symbol, .signal_venue, .signal_side, .signal_price,
    .spread_ratio, .last_of_pair
  );
endmodule
`default_nettype wire

// ===== sv/cvsd_front.sv =====
// Front end: price table memory, clearing pass, venue scan for min/max.
// Depends on cvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cvsd_front #(
  parameter int SYMBOL_COUNT = cvsd_pkg::SymbolCountDefault,
  parameter int VENUE_COUNT = cvsd_pkg::VenueCountDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [cvsd_pkg::SymW-1:0] symbol_index,
  input  wire logic [cvsd_pkg::VenW-1:0] venue_index,
  input  wire logic [31:0]               quote_ticks,
  output logic                           cand_valid,
  input  wire logic                      cand_ready,
  output cvsd_pkg::cand_t                cand
);
  localparam int VB = (VENUE_COUNT > 1) ? $clog2(VENUE_COUNT) : 1;
  localparam int SB = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int AB = SB + VB;
  localparam int Depth = SYMBOL_COUNT * (1 << VB);

  logic [31:0] mem [Depth];
  logic        seen [Depth];
  logic [31:0] rd_price;
  logic        rd_seen;

  cvsd_pkg::fe_state_t state, state_next;
  logic [AB:0]   clr_addr;
  logic [SB-1:0] sym;
  logic [cvsd_pkg::SymW-1:0] sym_full;
  logic [VB:0]   scan_v;
  logic [VB-1:0] rd_v;
  logic [VB-1:0] buy_v, sell_v;
  logic [31:0]   min_p, max_p;
  logic          have_min, have_max;
  logic [VB:0]   count;
  logic          accept, in_range, clr_done, scan_end;
  logic          we;
  logic [AB-1:0] waddr, raddr;
  logic [31:0]   wdata;
  logic          wseen;

  assign in_range = ({26'd0, symbol_index} < 32'(SYMBOL_COUNT)) &&
                    ({29'd0, venue_index} < 32'(VENUE_COUNT));
  assign accept = push && !full;
  assign clr_done = (clr_addr == (AB+1)'(Depth - 1));
  assign scan_end = (scan_v == (VB+1)'(VENUE_COUNT - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      cvsd_pkg::FE_CLEAR: if (clr_done) state_next = cvsd_pkg::FE_IDLE;
      cvsd_pkg::FE_IDLE:  if (accept && in_range) state_next = cvsd_pkg::FE_SCAN;
      cvsd_pkg::FE_SCAN:  if (scan_end) state_next = cvsd_pkg::FE_LAST;
      cvsd_pkg::FE_LAST:  state_next = cvsd_pkg::FE_PUSH;
      cvsd_pkg::FE_PUSH:  if (!cand_valid || cand_ready) state_next = cvsd_pkg::FE_IDLE;
      default:  state_next = cvsd_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    full = (state != cvsd_pkg::FE_IDLE);
    we = 1'b0;
    waddr = {sym, venue_index[VB-1:0]};
    wdata = quote_ticks;
    wseen = 1'b1;
    if (state == cvsd_pkg::FE_CLEAR) begin
      we = 1'b1;
      waddr = clr_addr[AB-1:0];
      wdata = '0;
      wseen = 1'b0;
    end else if (state == cvsd_pkg::FE_IDLE && accept && in_range) begin
      we = 1'b1;
      waddr = {symbol_index[SB-1:0], venue_index[VB-1:0]};
    end
    raddr = {sym, scan_v[VB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
      seen[waddr] <= wseen;
    end
    rd_price <= mem[raddr];
    rd_seen <= seen[raddr];
  end

  // one read in flight: rd_v names the entry now on rd_price
  logic rd_live;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvsd_pkg::FE_CLEAR;
      clr_addr <= '0;
      cand_valid <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cvsd_pkg::FE_CLEAR) clr_addr <= clr_addr + 1'b1;
      rd_live <= (state == cvsd_pkg::FE_SCAN);
      if (state == cvsd_pkg::FE_PUSH && (!cand_valid || cand_ready))
        cand_valid <= (count >= (VB+1)'(2)) && have_max && (min_p != 0) &&
                      (buy_v != sell_v);
      else if (cand_ready) cand_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_v <= scan_v[VB-1:0];
    if (state == cvsd_pkg::FE_IDLE) begin
      sym <= symbol_index[SB-1:0];
      sym_full <= symbol_index;
      scan_v <= '0;
      have_min <= 1'b0;
      have_max <= 1'b0;
      min_p <= '0;
      max_p <= '0;
      buy_v <= '0;
      sell_v <= '0;
      count <= '0;
    end else begin
      if (state == cvsd_pkg::FE_SCAN && !scan_end) scan_v <= scan_v + 1'b1;
      if (rd_live && rd_seen) begin
        count <= count + 1'b1;
        if (!have_min || rd_price < min_p) begin
          min_p <= rd_price;
          buy_v <= rd_v;
          have_min <= 1'b1;
        end
        if (rd_price > max_p) begin
          max_p <= rd_price;
          sell_v <= rd_v;
          have_max <= 1'b1;
        end
      end
    end
    if (state == cvsd_pkg::FE_PUSH && (!cand_valid || cand_ready)) begin
      cand.sym <= sym_full;
      cand.buy_venue <= cvsd_pkg::VenW'(buy_v);
      cand.sell_venue <= cvsd_pkg::VenW'(sell_v);
      cand.lo_ticks <= min_p;
      cand.hi_ticks <= max_p;
    end
  end

  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    state == cvsd_pkg::FE_CLEAR |-> full) else $error("accept during clear");
  a_cand_hold: assert property (@(posedge clk) disable iff (rst)
    cand_valid && !cand_ready |=> cand_valid && $stable(cand))
    else $error("candidate lost");
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> cand.lo_ticks < cand.hi_ticks) else $error("bad min/max");
endmodule
`default_nettype wire

// ===== sv/cvsd_back.sv =====
// Back end: restoring divider for the spread ratio, threshold test and
// two-beat result register. Depends on cvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cvsd_back #(
  parameter int FRACTION_BITS = cvsd_pkg::FractionBitsDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cand_valid,
  output logic                              cand_ready,
  input  wire cvsd_pkg::cand_t              cand,
  input  wire logic [31:0]                  threshold,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [cvsd_pkg::SymW-1:0]         signal_symbol,
  output logic [cvsd_pkg::VenW-1:0]         signal_venue,
  output logic                              signal_side,
  output logic [31:0]                       signal_price,
  output logic [31:0]                       spread_ratio,
  output logic                              last_of_pair
);
  localparam int NW = 32 + FRACTION_BITS;
  localparam int CB = $clog2(NW + 1);

  cvsd_pkg::be_state_t state, state_next;
  cvsd_pkg::cand_t c;
  logic [NW-1:0] num, quo;
  logic [32:0]   rem, rem_sh;
  logic [CB-1:0] cnt;
  logic [31:0]   ratio;
  logic [31:0]   ratio_now;
  logic          second;

  assign rem_sh = {rem[31:0], num[NW-1]};

  // saturated quotient, tested against the threshold in BE_CMP
  always_comb begin
    ratio_now = (quo[NW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cvsd_pkg::BE_IDLE: if (cand_valid) state_next = cvsd_pkg::BE_DIV;
      cvsd_pkg::BE_DIV:  if (cnt == CB'(NW - 1)) state_next = cvsd_pkg::BE_CMP;
      cvsd_pkg::BE_CMP:  state_next = (ratio_now >= threshold) ? cvsd_pkg::BE_EMIT
                                                               : cvsd_pkg::BE_IDLE;
      cvsd_pkg::BE_EMIT: if (pop && second) state_next = cvsd_pkg::BE_IDLE;
      default: state_next = cvsd_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    cand_ready = (state == cvsd_pkg::BE_IDLE);
    empty = (state != cvsd_pkg::BE_EMIT);
    signal_symbol = c.sym;
    signal_venue = second ? c.sell_venue : c.buy_venue;
    signal_side = second;
    signal_price = second ? c.hi_ticks : c.lo_ticks;
    spread_ratio = ratio;
    last_of_pair = second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvsd_pkg::BE_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cvsd_pkg::BE_CMP) second <= 1'b0;
      else if (state == cvsd_pkg::BE_EMIT && pop) second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cvsd_pkg::BE_IDLE: begin
        c <= cand;
        num <= {cand.hi_ticks - cand.lo_ticks, FRACTION_BITS'(0)};
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      cvsd_pkg::BE_DIV: begin
        cnt <= cnt + 1'b1;
        num <= num << 1;
        if (rem_sh >= {1'b0, c.lo_ticks}) begin
          rem <= rem_sh - {1'b0, c.lo_ticks};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
      cvsd_pkg::BE_CMP: ratio <= ratio_now;
      cvsd_pkg::BE_EMIT: ;
      default: ;
    endcase
  end

  a_pair: assert property (@(posedge clk) disable iff (rst)
    state == cvsd_pkg::BE_EMIT && pop && !second |=> state == cvsd_pkg::BE_EMIT && second)
    else $error("sell beat missing");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !cand_ready) else $error("accept while emitting");
  a_thresh: assert property (@(posedge clk) disable iff (rst)
    !empty |-> spread_ratio >= threshold) else $error("below threshold");
endmodule
`default_nettype wire

// ===== dv/cross_venue_spread_detector_unit_test.sv =====
// Testbench for cross_venue_spread_detector_unit: directed table, then random price
// updates checked against a local spread predictor. Depends on cvsd_pkg and the RTL.
`timescale 1ns / 1ps
module cross_venue_spread_detector_unit_test;

  typedef struct {
    logic [cvsd_pkg::SymW-1:0] sym;
    logic [cvsd_pkg::VenW-1:0] venue;
    logic            side;
    logic [31:0]     price;
    logic [31:0]     ratio;
    logic            last;
  } signal_t;

  typedef struct {
    logic [cvsd_pkg::SymW-1:0] sym;
    logic [cvsd_pkg::VenW-1:0] venue;
    logic [31:0]     price;
    int              n_exp;    // -1: predictor only
    logic [31:0]     exp_ratio;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic [cvsd_pkg::SymW-1:0] symbol_index = '0;
  logic [cvsd_pkg::VenW-1:0] venue_index = '0;
  logic [31:0] quote_ticks = '0;
  logic pop = 0;
  logic cfg_valid = 0;
  logic [31:0] cfg_data = '0;
  wire full, empty, cfg_ready, signal_side, last_of_pair;
  wire [cvsd_pkg::SymW-1:0] signal_symbol;
  wire [cvsd_pkg::VenW-1:0] signal_venue;
  wire [31:0] signal_price, spread_ratio;

  cross_venue_spread_detector_unit dut (
    .clk, .rst, .push, .full, .symbol_index, .venue_index, .quote_ticks,
    .empty, .pop, .signal_symbol, .signal_venue, .signal_side, .signal_price,
    .spread_ratio, .last_of_pair, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #2 clk = ~clk;

  logic [31:0] quote_price [64][8];
  logic        quote_seen [64][8];
  logic [31:0] threshold_q;
  signal_t     pending_signals[$];
  int errors = 0, updates_sent = 0, signals_seen = 0, idle_cycles = 0;
  int push_idle = 0, pop_idle = 0;
  bit timed_out = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic int predict_spread(input logic [cvsd_pkg::SymW-1:0] s,
                                        input logic [cvsd_pkg::VenW-1:0] v,
                                        input logic [31:0] p);
    logic [31:0] lo, hi;
    logic [cvsd_pkg::VenW-1:0] buy_v, sell_v;
    logic [63:0] q;
    logic [31:0] r;
    bit got_lo;
    int cnt;
    signal_t beat;
    lo = 0; hi = 0; buy_v = 0; sell_v = 0; got_lo = 0; cnt = 0;
    quote_price[s][v] = p;
    quote_seen[s][v] = 1;
    for (int i = 0; i < 8; i++) begin
      if (!quote_seen[s][i]) continue;
      cnt++;
      if (!got_lo || quote_price[s][i] < lo) begin
        lo = quote_price[s][i]; buy_v = cvsd_pkg::VenW'(i); got_lo = 1;
      end
      if (quote_price[s][i] > hi) begin
        hi = quote_price[s][i]; sell_v = cvsd_pkg::VenW'(i);
      end
    end
    if (cnt < 2 || hi == 0 || lo == 0 || buy_v == sell_v) return 0;
    q = ({32'd0, hi - lo} << 16) / {32'd0, lo};
    r = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    if (r < threshold_q) return 0;
    beat = '{s, buy_v, 1'b0, lo, r, 1'b0};
    pending_signals.insert(pending_signals.size(), beat);
    beat = '{s, sell_v, 1'b1, hi, r, 1'b1};
    pending_signals.insert(pending_signals.size(), beat);
    return 2;
  endfunction

  task automatic send_update(input logic [cvsd_pkg::SymW-1:0] s,
                             input logic [cvsd_pkg::VenW-1:0] v,
                             input logic [31:0] p, input int n_exp, input logic [31:0] r);
    int n;
    while ($urandom_range(99) < push_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; symbol_index <= s; venue_index <= v; quote_ticks <= p;
    do @(posedge clk); while (full);
    n = predict_spread(s, v, p);
    updates_sent++;
    if (n_exp >= 0) begin
      if (n != n_exp) report("directed count", 32'(n), 32'(n_exp));
      else if (n == 2 && pending_signals[$].ratio != r)
        report("directed ratio", pending_signals[$].ratio, r);
    end
  endtask

  task automatic drain_and_settle;
    push <= 0;
    while (pending_signals.size() != 0 && !timed_out) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] t);
    drain_and_settle();
    cfg_valid <= 1; cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    threshold_q = t;
  endtask

  // result side
  always @(posedge clk) begin
    signal_t e;
    if (!rst) begin
      if (pop && !empty) begin
        signals_seen++;
        if (pending_signals.size() == 0) begin
          $display("unexpected signal beat sym %0d", signal_symbol);
          errors++;
        end else begin
          e = pending_signals.pop_front();
          if (signal_symbol !== e.sym) report("symbol", 32'(signal_symbol), 32'(e.sym));
          if (signal_venue !== e.venue) report("venue", 32'(signal_venue), 32'(e.venue));
          if (signal_side !== e.side) report("side", 32'(signal_side), 32'(e.side));
          if (signal_price !== e.price) report("price", signal_price, e.price);
          if (spread_ratio !== e.ratio) report("ratio", spread_ratio, e.ratio);
          if (last_of_pair !== e.last) report("last", 32'(last_of_pair), 32'(e.last));
        end
      end
      pop <= ($urandom_range(99) >= pop_idle);
    end
  end

  // watchdog: clearing pass + division + long stalls fit well inside this
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  row_t directed[$];

  initial begin
    for (int i = 0; i < 64; i++)
      for (int j = 0; j < 8; j++) begin
        quote_price[i][j] = 0; quote_seen[i][j] = 0;
      end
    threshold_q = cvsd_pkg::ThresholdReset;
    // single venue, then max spread, zero min, same venue, ties, exact threshold
    directed = '{
      '{6'd0, 3'd0, 32'd100, 0, 0},
      '{6'd0, 3'd7, 32'hFFFF_FFFF, 2, 32'hFFFF_FFFF},
      '{6'd1, 3'd0, 32'd0, 0, 0},
      '{6'd1, 3'd1, 32'd50, 0, 0},
      '{6'd2, 3'd3, 32'd7, 0, 0},
      '{6'd2, 3'd3, 32'd9, 0, 0},
      '{6'd3, 3'd2, 32'd0, 0, 0},
      '{6'd3, 3'd5, 32'd0, 0, 0},
      '{6'd4, 3'd1, 32'd10, 0, 0},
      '{6'd4, 3'd4, 32'd10, 0, 0},
      '{6'd5, 3'd0, 32'd65536, 0, 0},
      '{6'd5, 3'd1, 32'd65602, 2, 32'd66},
      '{6'd6, 3'd0, 32'd65536, 0, 0},
      '{6'd6, 3'd1, 32'd65601, 0, 0},
      '{6'd63, 3'd7, 32'd1, 0, 0},
      '{6'd63, 3'd0, 32'd2, 2, 32'h0001_0000},
      '{6'd63, 3'd3, 32'd3, -1, 0},
      '{6'd0, 3'd0, 32'd0, 0, 0},
      '{6'd42, 3'd5, 32'hAAAA_5555, -1, 0},
      '{6'd42, 3'd2, 32'h5555_AAAA, -1, 0}
    };
    repeat (5) @(posedge clk);
    rst <= 0;
    push_idle = 16; pop_idle = 70;
    foreach (directed[i])
      send_update(directed[i].sym, directed[i].venue, directed[i].price,
                  directed[i].n_exp, directed[i].exp_ratio);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_threshold(32'd0);
        1: write_threshold(32'hFFFF_FFFF);
        2: begin
          write_threshold($urandom_range(32'h0002_0000));
          push_idle = 70; pop_idle = 16;
        end
        3: write_threshold(32'd66);
        4: begin
          write_threshold($urandom);
          push_idle = 0; pop_idle = 0;
        end
        default: write_threshold(32'h0000_1000);
      endcase
      for (int k = 0; k < 100; k++) begin
        logic [31:0] p;
        int mode;
        mode = $urandom_range(9);
        if (mode < 6) p = 32'd1000 + $urandom_range(200);
        else if (mode < 8) p = $urandom_range(3);
        else p = $urandom;
        send_update(cvsd_pkg::SymW'($urandom_range(7) == 0 ? $urandom_range(63)
                                                            : $urandom_range(3)),
                    cvsd_pkg::VenW'($urandom_range(7)), p, -1, 0);
      end
    end
    drain_and_settle();
    $display("sent %0d price updates, checked %0d signal beats, six threshold settings",
             updates_sent, signals_seen);
    if (errors == 0 && pending_signals.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
